FILE: hw/rtl/kmst_pkg.sv
`default_nettype none

package kmst_pkg;

  // table geometry
  localparam int unsigned MAX_VERTICES = 1024;
  localparam int unsigned VERT_W       = $clog2(MAX_VERTICES);
  localparam int unsigned VC_W         = 11;
  localparam int unsigned CNT_W        = 10;

  localparam logic [VERT_W-1:0] LAST_VERTEX = VERT_W'(MAX_VERTICES - 1);
  localparam logic [VC_W-1:0]   VC_MAX      = VC_W'(MAX_VERTICES);
  localparam logic [VC_W-1:0]   VC_RESET    = VC_W'(1024);

  // command codes
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  // engine states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CLEAR  = 6'b000010,
    ST_FIND_A = 6'b000100,
    ST_COMP_A = 6'b001000,
    ST_FIND_B = 6'b010000,
    ST_COMP_B = 6'b100000
  } state_e;

  // write port of the parent table
  typedef struct packed {
    logic              we;
    logic [VERT_W-1:0] addr;
    logic [VERT_W-1:0] data;
  } ram_wr_t;

  // vertex count saturated to the table size
  function automatic logic [VC_W-1:0] eff_count(input logic [VC_W-1:0] vc);
    eff_count = (vc > VC_MAX) ? VC_MAX : vc;
  endfunction

  // spanning tree reached: kept edges equal vertex count minus one
  function automatic logic tree_done(input logic [CNT_W-1:0] cnt,
                                     input logic [VC_W-1:0]  vc);
    logic [VC_W-1:0] n;
    n = eff_count(vc);
    tree_done = (n != '0) && ({{(VC_W-CNT_W){1'b0}}, cnt} == (n - VC_W'(1)));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kruskal_union_find_mst_core.sv
// edge transaction: per endpoint only a root check if it is its own root, else a walk to
// find the root and a second walk to compress the path, one parent link per cycle through one read port
// clear transaction: one table entry written per cycle; a bad endpoint leaves the table untouched
// one transaction in flight; registered strobe done_o comes in the cycle after the work ends
// reset: vertex_count 1024, count zero, then a clearing pass with busy high
// and no result; the receiver cannot stall, results are never held
`default_nettype none

module kruskal_union_find_mst_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         cfg_we_i,
  input  wire logic [kmst_pkg::VC_W-1:0]    cfg_data_i,
  input  wire logic                         command_i,
  input  wire logic [kmst_pkg::VERT_W-1:0]  end_a_i,
  input  wire logic [kmst_pkg::VERT_W-1:0]  end_b_i,
  output logic                              done_o,
  output logic                              taken_o,
  output logic      [kmst_pkg::CNT_W-1:0]   edges_taken_o,
  output logic                              tree_complete_o,
  output logic                              bad_endpoint_o
);
  import kmst_pkg::*;

  state_e            state_q, state_d;
  logic [VERT_W-1:0] cur_q, cur_d;
  logic [VERT_W-1:0] origin_q, origin_d;
  logic [VERT_W-1:0] root_q, root_d;
  logic [VERT_W-1:0] root_a_q, root_a_d;
  logic [VERT_W-1:0] end_b_q, end_b_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [VC_W-1:0]   vc_q;
  logic [VERT_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              clr_report_q, clr_report_d;
  logic              done_q, done_d;
  logic              taken_q, taken_d;
  logic [CNT_W-1:0]  edges_q, edges_d;
  logic              complete_q, complete_d;
  logic              bad_q, bad_d;

  ram_wr_t           ram_wr;
  logic [VERT_W-1:0] ram_rd_addr;
  logic [VERT_W-1:0] ram_rd_data;
  logic [VC_W-1:0]   n_eff;
  logic              endpoint_bad;

  kmst_parent_ram u_parent_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // endpoint range check
  assign n_eff        = eff_count(vc_q);
  assign endpoint_bad = ({1'b0, end_a_i} >= n_eff) || ({1'b0, end_b_i} >= n_eff);

  assign busy = (state_q != ST_IDLE);

  // engine control
  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    origin_d     = origin_q;
    root_d       = root_q;
    root_a_d     = root_a_q;
    end_b_d      = end_b_q;
    count_d      = count_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    done_d       = 1'b0;
    taken_d      = taken_q;
    edges_d      = edges_q;
    complete_d   = complete_q;
    bad_d        = bad_q;
    ram_rd_addr  = cur_q;
    ram_wr.we    = 1'b0;
    ram_wr.addr  = cur_q;
    ram_wr.data  = root_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (command_i == CMD_CLEAR) begin
            state_d      = ST_CLEAR;
            clr_cnt_d    = '0;
            clr_report_d = 1'b1;
          end else if (endpoint_bad) begin
            done_d     = 1'b1;
            taken_d    = 1'b0;
            edges_d    = count_q;
            complete_d = tree_done(count_q, vc_q);
            bad_d      = 1'b1;
          end else begin
            origin_d    = end_a_i;
            cur_d       = end_a_i;
            end_b_d     = end_b_i;
            ram_rd_addr = end_a_i;
            state_d     = ST_FIND_A;
          end
        end
      end

      // sweep: every vertex becomes its own root
      ST_CLEAR: begin
        ram_wr.we   = 1'b1;
        ram_wr.addr = clr_cnt_q;
        ram_wr.data = clr_cnt_q;
        clr_cnt_d   = clr_cnt_q + VERT_W'(1);
        if (clr_cnt_q == LAST_VERTEX) begin
          state_d      = ST_IDLE;
          count_d      = '0;
          clr_report_d = 1'b0;
          if (clr_report_q) begin
            done_d     = 1'b1;
            taken_d    = 1'b0;
            edges_d    = '0;
            complete_d = tree_done('0, vc_q);
            bad_d      = 1'b0;
          end
        end
      end

      // follow parent links until a node points at itself
      ST_FIND_A, ST_FIND_B: begin
        if (ram_rd_data == cur_q) begin
          root_d = cur_q;
          if (cur_q == origin_q) begin
            // endpoint is its own root, nothing to compress
            if (state_q == ST_FIND_A) begin
              root_a_d    = cur_q;
              origin_d    = end_b_q;
              cur_d       = end_b_q;
              ram_rd_addr = end_b_q;
              state_d     = ST_FIND_B;
            end else begin
              state_d    = ST_IDLE;
              done_d     = 1'b1;
              bad_d      = 1'b0;
              taken_d    = 1'b0;
              edges_d    = count_q;
              complete_d = tree_done(count_q, vc_q);
              if (root_a_q != cur_q) begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = root_a_q;
                ram_wr.data = cur_q;
                count_d     = count_q + CNT_W'(1);
                taken_d     = 1'b1;
                edges_d     = count_q + CNT_W'(1);
                complete_d  = tree_done(count_q + CNT_W'(1), vc_q);
              end
            end
          end else begin
            cur_d       = origin_q;
            ram_rd_addr = origin_q;
            state_d     = (state_q == ST_FIND_A) ? ST_COMP_A : ST_COMP_B;
          end
        end else begin
          cur_d       = ram_rd_data;
          ram_rd_addr = ram_rd_data;
        end
      end

      // walk the path again, pointing each node at the root
      ST_COMP_A, ST_COMP_B: begin
        if (cur_q == root_q) begin
          if (state_q == ST_COMP_A) begin
            root_a_d    = root_q;
            origin_d    = end_b_q;
            cur_d       = end_b_q;
            ram_rd_addr = end_b_q;
            state_d     = ST_FIND_B;
          end else begin
            state_d    = ST_IDLE;
            done_d     = 1'b1;
            bad_d      = 1'b0;
            taken_d    = 1'b0;
            edges_d    = count_q;
            complete_d = tree_done(count_q, vc_q);
            if (root_a_q != root_q) begin
              ram_wr.we   = 1'b1;
              ram_wr.addr = root_a_q;
              ram_wr.data = root_q;
              count_d     = count_q + CNT_W'(1);
              taken_d     = 1'b1;
              edges_d     = count_q + CNT_W'(1);
              complete_d  = tree_done(count_q + CNT_W'(1), vc_q);
            end
          end
        end else begin
          ram_wr.we   = 1'b1;
          ram_wr.addr = cur_q;
          ram_wr.data = root_q;
          cur_d       = ram_rd_data;
          ram_rd_addr = ram_rd_data;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state; reset starts with a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      count_q      <= '0;
      vc_q         <= VC_RESET;
      clr_cnt_q    <= '0;
      clr_report_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
      done_q       <= done_d;
      if (cfg_we_i) begin
        vc_q <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    origin_q   <= origin_d;
    root_q     <= root_d;
    root_a_q   <= root_a_d;
    end_b_q    <= end_b_d;
    taken_q    <= taken_d;
    edges_q    <= edges_d;
    complete_q <= complete_d;
    bad_q      <= bad_d;
  end

  assign done_o          = done_q;
  assign taken_o         = taken_q;
  assign edges_taken_o   = edges_q;
  assign tree_complete_o = complete_q;
  assign bad_endpoint_o  = bad_q;

endmodule

`default_nettype wire

FILE: hw/rtl/kmst_parent_ram.sv
`default_nettype none

module kmst_parent_ram (
  input  wire logic                          clk_i,
  input  wire kmst_pkg::ram_wr_t             wr_i,
  input  wire logic [kmst_pkg::VERT_W-1:0]   rd_addr_i,
  output logic      [kmst_pkg::VERT_W-1:0]   rd_data_o
);
  import kmst_pkg::*;

  logic [VERT_W-1:0] mem [MAX_VERTICES];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_o <= mem[rd_addr_i];
  end

endmodule

`default_nettype wire

FILE: tb/tb_kruskal_union_find_mst_core.sv
`timescale 1ns / 1ps

module tb_kruskal_union_find_mst_core;
  import kmst_pkg::*;

  // one result transaction of the engine
  typedef struct packed {
    logic             taken;
    logic [CNT_W-1:0] edges_taken;
    logic             tree_complete;
    logic             bad_endpoint;
  } mst_result_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic              cfg_we_i      = 1'b0;
  logic [VC_W-1:0]   cfg_data_i    = '0;
  logic              command_i     = CMD_CLEAR;
  logic [VERT_W-1:0] end_a_i       = '0;
  logic [VERT_W-1:0] end_b_i       = '0;
  logic              done_o;
  logic              taken_o;
  logic [CNT_W-1:0]  edges_taken_o;
  logic              tree_complete_o;
  logic              bad_endpoint_o;

  // shadow forest and settings
  logic [VERT_W-1:0] forest_parent [MAX_VERTICES];
  logic [CNT_W-1:0]  forest_edges;
  logic [VC_W-1:0]   vertex_count_shadow;

  mst_result_t pending_results [$];
  mst_result_t got_res;
  mst_result_t want_res;
  int          err_cnt = 0;
  int          sender_idle_pct = 0;

  kruskal_union_find_mst_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .end_a_i         (end_a_i),
    .end_b_i         (end_b_i),
    .done_o          (done_o),
    .taken_o         (taken_o),
    .edges_taken_o   (edges_taken_o),
    .tree_complete_o (tree_complete_o),
    .bad_endpoint_o  (bad_endpoint_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // every vertex back to its own root
  function automatic void clear_forest_model();
    for (int v = 0; v < MAX_VERTICES; v++) forest_parent[v] = VERT_W'(v);
    forest_edges = '0;
  endfunction

  function automatic int unsigned usable_vertices();
    return (vertex_count_shadow > VC_W'(MAX_VERTICES)) ? MAX_VERTICES
                                                       : int'(vertex_count_shadow);
  endfunction

  // root search, then point every visited node at the root
  function automatic logic [VERT_W-1:0] find_and_compress(input logic [VERT_W-1:0] v);
    logic [VERT_W-1:0] root;
    logic [VERT_W-1:0] cur;
    logic [VERT_W-1:0] nxt;
    int                guard;
    root  = v;
    guard = 0;
    while (forest_parent[root] != root && guard < MAX_VERTICES) begin
      root = forest_parent[root];
      guard++;
    end
    cur   = v;
    guard = 0;
    while (cur != root && guard < MAX_VERTICES) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      guard++;
    end
    return root;
  endfunction

  // expected result of one accepted transaction, updates the shadow forest
  function automatic mst_result_t union_find_step(input logic cmd,
                                                  input logic [VERT_W-1:0] a,
                                                  input logic [VERT_W-1:0] b);
    mst_result_t       res;
    int unsigned       n;
    logic [VERT_W-1:0] ra;
    logic [VERT_W-1:0] rb;
    res = '0;
    n   = usable_vertices();
    if (cmd == CMD_CLEAR) begin
      clear_forest_model();
    end else if (int'(a) >= n || int'(b) >= n) begin
      res.bad_endpoint = 1'b1;
    end else begin
      ra = find_and_compress(a);
      rb = find_and_compress(b);
      if (ra != rb) begin
        forest_parent[ra] = rb;
        forest_edges      = forest_edges + 1'b1;
        res.taken         = 1'b1;
      end
    end
    res.edges_taken   = forest_edges;
    res.tree_complete = (n >= 1) && (int'(forest_edges) == n - 1);
    return res;
  endfunction

  function automatic void log_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // result checker, one transaction per strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      got_res = '{taken_o, edges_taken_o, tree_complete_o, bad_endpoint_o};
      if (pending_results.size() == 0) begin
        log_error("result with no transaction outstanding");
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.taken !== want_res.taken ||
            got_res.edges_taken !== want_res.edges_taken ||
            got_res.tree_complete !== want_res.tree_complete ||
            got_res.bad_endpoint !== want_res.bad_endpoint)
          log_error($sformatf({"exp taken=%0b cnt=%0d done=%0b bad=%0b, ",
                               "got taken=%0b cnt=%0d done=%0b bad=%0b"},
                              want_res.taken, want_res.edges_taken,
                              want_res.tree_complete, want_res.bad_endpoint,
                              got_res.taken, got_res.edges_taken,
                              got_res.tree_complete, got_res.bad_endpoint));
      end
    end
  end

  // drive one transaction and wait for it to be accepted
  task automatic send_item(input logic cmd, input logic [VERT_W-1:0] a,
                           input logic [VERT_W-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd;
    end_a_i   <= a;
    end_b_i   <= b;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(union_find_step(cmd, a, b));
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [VC_W-1:0] value);
    wait_idle();
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i            <= 1'b0;
    vertex_count_shadow  = value;
  endtask

  function automatic logic [VC_W-1:0] pick_vertex_count();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return VC_W'($urandom_range(1));
    if (r < 70) return VC_W'($urandom_range(40, 2));
    if (r < 88) return VC_W'($urandom_range(1024, 41));
    return VC_W'($urandom_range(2047, 1025));
  endfunction

  // field extremes, self loop, same-tree edge and a long parent chain
  task automatic test_full_range_edges();
    send_item(CMD_EDGE, 10'd0, 10'd1023);
    send_item(CMD_EDGE, 10'd1023, 10'd0);
    send_item(CMD_EDGE, 10'd5, 10'd5);
    for (int i = 100; i < 106; i++) send_item(CMD_EDGE, VERT_W'(i), VERT_W'(i + 1));
    send_item(CMD_EDGE, 10'd100, 10'd0);
    send_item(CMD_EDGE, 10'd100, 10'd1023);
    send_item(CMD_EDGE, 10'd682, 10'd341);
  endtask

  // tiny, empty and saturated vertex counts
  task automatic test_small_counts();
    write_vertex_count(VC_W'(2));
    send_item(CMD_CLEAR, 10'd1023, 10'd1023);
    send_item(CMD_EDGE, 10'd0, 10'd1);
    send_item(CMD_EDGE, 10'd1, 10'd2);
    send_item(CMD_EDGE, 10'd1, 10'd0);
    write_vertex_count(VC_W'(1));
    send_item(CMD_CLEAR, 10'd0, 10'd0);
    send_item(CMD_EDGE, 10'd0, 10'd0);
    send_item(CMD_EDGE, 10'd0, 10'd1);
    write_vertex_count(VC_W'(0));
    send_item(CMD_EDGE, 10'd0, 10'd0);
    send_item(CMD_CLEAR, 10'd0, 10'd0);
    write_vertex_count(VC_W'(2047));
    send_item(CMD_CLEAR, 10'd0, 10'd0);
    send_item(CMD_EDGE, 10'd1023, 10'd1022);
  endtask

  // new vertex count keeps the forest
  task automatic test_recount_without_clear();
    write_vertex_count(VC_W'(4));
    send_item(CMD_CLEAR, 10'd0, 10'd0);
    send_item(CMD_EDGE, 10'd0, 10'd1);
    send_item(CMD_EDGE, 10'd2, 10'd3);
    write_vertex_count(VC_W'(3));
    send_item(CMD_EDGE, 10'd1, 10'd2);
    send_item(CMD_EDGE, 10'd3, 10'd0);
  endtask

  // rounds of clear plus random edges, with noise, stray clears and recounts
  task automatic test_random_forests(input int n_items);
    int          sent;
    int          round_len;
    int          r;
    int unsigned n;
    sent = 0;
    while (sent < n_items) begin
      write_vertex_count(pick_vertex_count());
      send_item(CMD_CLEAR, VERT_W'($urandom), VERT_W'($urandom));
      sent++;
      n         = usable_vertices();
      round_len = (n < 2) ? 6 : ((3 * n + 4 > 160) ? 160 : 3 * n + 4);
      for (int k = 0; k < round_len && sent < n_items; k++) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_item(CMD_CLEAR, VERT_W'($urandom), VERT_W'($urandom));
        end else if (r < 6) begin
          write_vertex_count(pick_vertex_count());
          n = usable_vertices();
          continue;
        end else if (r < 16 || n == 0) begin
          send_item(CMD_EDGE, VERT_W'($urandom), VERT_W'($urandom));
        end else begin
          send_item(CMD_EDGE, VERT_W'($urandom_range(n - 1)),
                    VERT_W'($urandom_range(n - 1)));
        end
        sent++;
      end
    end
  endtask

  // run limit
  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

  // test sequence
  initial begin
    vertex_count_shadow = VC_RESET;
    clear_forest_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sender_idle_pct = 34;
    test_full_range_edges();
    test_small_counts();
    test_recount_without_clear();
    test_random_forests(430);
    sender_idle_pct = 66;
    test_random_forests(430);
    sender_idle_pct = 0;
    test_random_forests(440);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (pending_results.size() != 0)
      log_error($sformatf("%0d results never arrived", pending_results.size()));
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: kruskal_union_find_mst_core.f
hw/rtl/kmst_pkg.sv
hw/rtl/kmst_parent_ram.sv
hw/rtl/kruskal_union_find_mst_core.sv
tb/tb_kruskal_union_find_mst_core.sv
